FILE: design/rhb_pkg.sv
`timescale 1ns / 1ps

package rhb_pkg;

    // Sizing of the counter store and the bin arithmetic
    localparam int MAX_BINS    = 256;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int NUM_W       = BIN_W + 1;
    localparam int VAL_W       = 32;
    localparam int PROD_W      = VAL_W + NUM_W;

    // Operation codes of the input item
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_BIN_COUNT  = 2'd2;
    localparam logic [1:0] REG_AUTO_MODE  = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] sample;
        logic [7:0]         bin_select;
    } item_t;

    typedef struct packed {
        logic [7:0]  bin;
        logic        in_range;
        logic [31:0] bin_total;
        logic [31:0] out_range_total;
    } result_t;

    typedef struct packed {
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [8:0]         bin_count;
        logic               auto_mode;
    } cfg_t;

endpackage

FILE: design/range_histogram_binner_unit.sv
`timescale 1ns / 1ps

// Fixed-range histogram of signed Q16.16 samples.
// Input channel (item_valid / item_stall / item) carries one operation per
// transaction: add a sample, read one bin's count, or clear all counters.
// Each input transaction yields exactly one result transaction on
// result_valid / result_stall / result, in order.
// Configuration writes (range edges, bin count, auto mode) go over
// cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready stays high, and
// writes belong between items, while no transaction is in flight.
// Sequence: an in-range add with a nonempty range passes a multiply state,
// a 9-step radix-2 divider for the bin index, then a read and a write-back
// of the counter memory; a read, or an in-range add with an empty range,
// passes only the read and write-back; a rejected sample, a clear or an
// unused code goes straight to the write-back. One item is in work at a time.
// The output register lets the next item be accepted while a result waits;
// a stalled result holds its value and blocks only the final write-back.
// Reset clears all bin counters (via per-entry valid bits), the rejected
// count and the registers to their defaults; no clearing sweep is needed.
module range_histogram_binner_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  rhb_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output rhb_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import rhb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DIV   = 5'b00100,
        S_READ  = 5'b01000,
        S_WRITE = 5'b10000
    } state_t;

    cfg_t             cfg;
    state_t           state_reg;
    state_t           state_next;

    logic [1:0]       op_reg;
    logic [7:0]       sel_reg;
    logic             hit_reg;
    logic             oob_reg;
    logic [VAL_W-1:0] off_reg;
    logic [VAL_W-1:0] span_reg;
    logic [NUM_W-1:0] mul_reg;
    logic [NUM_W-1:0] last_reg;
    logic [BIN_W-1:0] idx_reg;
    count_t           rejected_reg;
    result_t          result_reg;
    logic             result_valid_reg;

    logic             item_fire;
    logic             result_free;
    logic             in_ok;
    logic             span_pos;
    logic [NUM_W-1:0] n_min;
    logic [NUM_W-1:0] n_eff;
    logic [PROD_W-1:0] product;
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [NUM_W-1:0] quo_clamped;
    logic             mem_clear;
    logic             mem_wr;
    logic             mem_rd;
    count_t           mem_rd_data;
    count_t           count_inc;

    rhb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rhb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    rhb_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mem_clear),
        .wr_en   (mem_wr),
        .wr_addr (idx_reg),
        .wr_data (count_inc),
        .rd_en   (mem_rd),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    // Handshake
    assign item_stall   = (state_reg != S_IDLE);
    assign item_fire    = item_valid && !item_stall;
    assign result_free  = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Range test and effective bin count for the incoming sample
    assign span_pos = cfg.range_high > cfg.range_low;
    assign in_ok    = (item.sample >= cfg.range_low) &&
                      (cfg.auto_mode ? (item.sample <= cfg.range_high)
                                     : (item.sample <  cfg.range_high));
    assign n_min    = cfg.auto_mode ? NUM_W'(2) : NUM_W'(1);

    always_comb
    begin
        if (NUM_W'(cfg.bin_count) < n_min)
            n_eff = n_min;
        else if (32'(cfg.bin_count) > MAX_BINS)
            n_eff = NUM_W'(MAX_BINS);
        else
            n_eff = NUM_W'(cfg.bin_count);
    end

    // Scale the offset; the divider registers the product
    assign product     = PROD_W'(off_reg) * PROD_W'(mul_reg);
    assign div_start   = (state_reg == S_MUL);
    assign quo_clamped = (div_quo > last_reg) ? last_reg : div_quo;

    // Memory control
    assign mem_clear = item_fire && (item.op == OP_CLEAR);
    assign mem_rd    = (state_reg == S_READ);
    assign mem_wr    = (state_reg == S_WRITE) && result_free && hit_reg;
    assign count_inc = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    case (item.op)
                        OP_ADD:
                        begin
                            if (in_ok && span_pos)
                                state_next = S_MUL;
                            else if (in_ok)
                                state_next = S_READ;
                            else
                                state_next = S_WRITE;
                        end
                        OP_READ: state_next = S_READ;
                        default: state_next = S_WRITE;
                    endcase
                end
            end
            S_MUL:   state_next = S_DIV;
            S_DIV:   state_next = div_done ? S_READ : S_DIV;
            S_READ:  state_next = S_WRITE;
            S_WRITE: state_next = result_free ? S_IDLE : S_WRITE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers: state, rejected count, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rejected_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (item_fire && item.op == OP_ADD && !in_ok && rejected_reg != '1)
                rejected_reg <= rejected_reg + 1'b1;
            else if (mem_clear)
                rejected_reg <= '0;
            if (state_reg == S_WRITE && result_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Capture the transaction's operands
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            op_reg   <= item.op;
            sel_reg  <= item.bin_select;
            hit_reg  <= (item.op == OP_ADD) && in_ok;
            oob_reg  <= 32'(item.bin_select) >= MAX_BINS;
            off_reg  <= VAL_W'(item.sample - cfg.range_low);
            span_reg <= VAL_W'(cfg.range_high - cfg.range_low);
            mul_reg  <= cfg.auto_mode ? n_eff - 1'b1 : n_eff;
            last_reg <= n_eff - 1'b1;
            idx_reg  <= (item.op == OP_READ) ? BIN_W'(item.bin_select) : '0;
        end
        else if (state_reg == S_DIV && div_done)
        begin
            idx_reg <= BIN_W'(quo_clamped);
        end
    end

    // Form the result once the output register is free
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE && result_free)
        begin
            result_reg.out_range_total <= 32'(rejected_reg);
            if (hit_reg)
            begin
                result_reg.bin       <= 8'(idx_reg);
                result_reg.in_range  <= 1'b1;
                result_reg.bin_total <= 32'(count_inc);
            end
            else if (op_reg == OP_READ)
            begin
                result_reg.bin       <= sel_reg;
                result_reg.in_range  <= 1'b0;
                result_reg.bin_total <= oob_reg ? 32'd0 : 32'(mem_rd_data);
            end
            else
            begin
                result_reg.bin       <= 8'd0;
                result_reg.in_range  <= 1'b0;
                result_reg.bin_total <= 32'd0;
            end
        end
    end

endmodule

FILE: design/rhb_cfg.sv
`timescale 1ns / 1ps

module rhb_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output rhb_pkg::cfg_t cfg
);
    import rhb_pkg::*;

    cfg_t cfg_reg;

    // Always able to take a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Update the addressed register on each write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low  <= 32'sd0;
            cfg_reg.range_high <= 32'sd65536;
            cfg_reg.bin_count  <= 9'd16;
            cfg_reg.auto_mode  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RANGE_LOW:  cfg_reg.range_low  <= cfg_data;
                REG_RANGE_HIGH: cfg_reg.range_high <= cfg_data;
                REG_BIN_COUNT:  cfg_reg.bin_count  <= cfg_data[8:0];
                REG_AUTO_MODE:  cfg_reg.auto_mode  <= cfg_data[0];
                default:        cfg_reg.auto_mode  <= cfg_reg.auto_mode;
            endcase
        end
    end

endmodule

FILE: design/rhb_div.sv
`timescale 1ns / 1ps

module rhb_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rhb_pkg::PROD_W-1:0]  dividend,
    input  logic [rhb_pkg::VAL_W-1:0]   divisor,
    output logic                        done,
    output logic [rhb_pkg::NUM_W-1:0]   quotient
);
    import rhb_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [VAL_W-1:0] rem_reg;
    logic [VAL_W-1:0] divisor_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VAL_W:0]   trial;
    logic             take;

    // Quotient is known to fit NUM_W bits, so the upper dividend bits start below the divisor
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign take     = trial >= {1'b0, divisor_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    // Control: step count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: one restoring step per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= dividend[PROD_W-1:NUM_W];
            quo_reg     <= dividend[NUM_W-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? VAL_W'(trial - {1'b0, divisor_reg}) : trial[VAL_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

endmodule

FILE: design/rhb_ram.sv
`timescale 1ns / 1ps

module rhb_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       wr_en,
    input  logic [rhb_pkg::BIN_W-1:0]  wr_addr,
    input  rhb_pkg::count_t            wr_data,
    input  logic                       rd_en,
    input  logic [rhb_pkg::BIN_W-1:0]  rd_addr,
    output rhb_pkg::count_t            rd_data
);
    import rhb_pkg::*;

    count_t              mem [MAX_BINS];
    logic [MAX_BINS-1:0] valid_reg;
    count_t              rd_data_reg;
    logic                rd_valid_reg;

    // Entry valid bits: an entry never written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Storage array with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

import rhb_pkg::*;

// Unused op code: the block must answer it with the rejected count only
localparam logic [1:0] OP_NOP = 2'd3;

// Tracks bin counters and the rejected count alongside the block and
// checks each result transaction against the predicted one.
class bin_count_tracker;
    logic signed [31:0] edge_lo;
    logic signed [31:0] edge_hi;
    logic [8:0]         bins_used;
    logic               auto_on;
    logic [31:0]        counts [MAX_BINS];
    logic [31:0]        rejected;
    result_t            binned_results [$];
    int                 errors;

    function new();
        edge_lo   = 32'sd0;
        edge_hi   = 32'sd65536;
        bins_used = 9'd16;
        auto_on   = 1'b0;
        rejected  = '0;
        errors    = 0;
        foreach (counts[i])
            counts[i] = '0;
    endfunction

    function int pending();
        return binned_results.size();
    endfunction

    task report(string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            REG_RANGE_LOW:  edge_lo = data;
            REG_RANGE_HIGH: edge_hi = data;
            REG_BIN_COUNT:  bins_used = data[8:0];
            REG_AUTO_MODE:  auto_on = data[0];
            default: ;
        endcase
    endfunction

    // Saturating counter step
    function logic [31:0] bump(logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    // Work out the result of one operation and advance the counters
    function result_t predict_bin_result(item_t it);
        result_t               r;
        longint                x;
        longint                lo;
        longint                hi;
        longint unsigned       n;
        longint unsigned       idx;
        longint unsigned       mul;
        bit                    hit;
        r  = '0;
        x  = longint'($signed(it.sample));
        lo = longint'($signed(edge_lo));
        hi = longint'($signed(edge_hi));
        case (it.op)
            OP_ADD:
            begin
                n = bins_used;
                if (auto_on && n < 2)
                    n = 2;
                else if (n < 1)
                    n = 1;
                if (n > MAX_BINS)
                    n = MAX_BINS;
                hit = auto_on ? (x >= lo && x <= hi) : (x >= lo && x < hi);
                if (hit)
                begin
                    idx = 0;
                    if (hi > lo)
                    begin
                        mul = auto_on ? n - 1 : n;
                        idx = (unsigned'(x - lo) * mul) / unsigned'(hi - lo);
                        if (idx > n - 1)
                            idx = n - 1;
                    end
                    counts[idx] = bump(counts[idx]);
                    r.bin       = idx[7:0];
                    r.in_range  = 1'b1;
                    r.bin_total = counts[idx];
                end
                else
                    rejected = bump(rejected);
            end
            OP_READ:
            begin
                r.bin       = it.bin_select;
                r.bin_total = counts[it.bin_select];
            end
            OP_CLEAR:
            begin
                foreach (counts[i])
                    counts[i] = '0;
                rejected = '0;
            end
            default: ;
        endcase
        r.out_range_total = rejected;
        return r;
    endfunction

    function void record_op(item_t it);
        binned_results.push_back(predict_bin_result(it));
    endfunction

    task check_result(result_t got);
        result_t want;
        if (binned_results.size() == 0)
        begin
            report($sformatf("result with nothing expected: %h", got));
            return;
        end
        want = binned_results.pop_front();
        if (got.bin !== want.bin)
            report($sformatf("bin %0d, expected %0d", got.bin, want.bin));
        if (got.in_range !== want.in_range)
            report($sformatf("in_range %b, expected %b", got.in_range, want.in_range));
        if (got.bin_total !== want.bin_total)
            report($sformatf("bin_total %0d, expected %0d (bin %0d)",
                             got.bin_total, want.bin_total, want.bin));
        if (got.out_range_total !== want.out_range_total)
            report($sformatf("out_range_total %0d, expected %0d",
                             got.out_range_total, want.out_range_total));
    endtask
endclass

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 150;
    localparam int RAND_PHASES = 11;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic        idle_on = 1'b1;
    logic        hold_go = 1'b0;
    int          hold_left = 0;
    int          cycles = 0;

    bin_count_tracker tracker;

    range_histogram_binner_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL range_histogram_binner_unit");
            $finish;
        end
    end

    // Long receiver hold-off, counted down here once requested
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
    end

    // Receiver stall: random idling plus the hold-off
    always @(posedge clk)
        result_stall <= (hold_left != 0) || (idle_on && $urandom_range(0, 99) < 9);

    // Observe every transaction on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                tracker.check_result(result);
            if (item_valid && !item_stall)
                tracker.record_op(item);
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    function automatic item_t make_item(logic [1:0] op, logic [31:0] sample,
                                         logic [7:0] sel);
        item_t it;
        it.op         = op;
        it.sample     = sample;
        it.bin_select = sel;
        return it;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(item_t it);
        if (idle_on && $urandom_range(0, 99) < 9)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write all four registers back to back; only called while drained
    task automatic program_regs(logic [31:0] lo, logic [31:0] hi, logic [8:0] nb,
                                logic am, bit junk);
        logic [31:0] vals [4];
        logic [1:0]  idxs [4];
        vals[0] = lo;
        vals[1] = hi;
        vals[2] = junk ? {23'($urandom_range(0, 32'h7F_FFFF)), nb} : {23'd0, nb};
        vals[3] = junk ? {31'($urandom_range(0, 32'h7FFF_FFFF)), am} : {31'd0, am};
        idxs[0] = REG_RANGE_LOW;
        idxs[1] = REG_RANGE_HIGH;
        idxs[2] = REG_BIN_COUNT;
        idxs[3] = REG_AUTO_MODE;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One phase of random operations, samples aimed at the current range
    task automatic random_phase(longint lo, longint hi, int nb);
        item_t   it;
        int      pick;
        int      top;
        longint  x;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            pick = $urandom_range(0, 99);
            top  = (nb < 1) ? 0 : ((nb > 256) ? 255 : nb - 1);
            if (pick < 75)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65 && hi > lo)
                    x = lo + longint'({$urandom, $urandom}
                                      % unsigned'(hi - lo + 1));
                else if (pick < 85)
                    case ($urandom_range(0, 3))
                        0: x = lo;
                        1: x = hi;
                        2: x = hi - 1;
                        default: x = lo - 1;
                    endcase
                else
                    x = longint'($signed($urandom));
                it = make_item(OP_ADD, clamp32(x), 8'($urandom_range(0, 255)));
            end
            else if (pick < 93)
                it = make_item(OP_READ, $urandom,
                               ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, top))
                                                          : 8'($urandom_range(0, 255)));
            else if (pick < 97)
                it = make_item(OP_NOP, $urandom, 8'($urandom_range(0, 255)));
            else
                it = make_item(OP_CLEAR, $urandom, 8'($urandom_range(0, 255)));
            send_item(it);
        end
    endtask

    initial
    begin
        longint lo;
        longint hi;
        int     nb;
        bit     am;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_RANGE_LOW;
        cfg_data   = '0;
        tracker    = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: [0, 1.0) in 16 bins, edges, rejects, reads, clear
        send_item(make_item(OP_ADD, 32'h0000_0000, 8'd0));
        send_item(make_item(OP_ADD, 32'h0000_FFFF, 8'd0));
        send_item(make_item(OP_ADD, 32'h0000_8000, 8'd0));
        send_item(make_item(OP_ADD, 32'h0001_0000, 8'd0));
        send_item(make_item(OP_ADD, 32'hFFFF_FFFF, 8'd0));
        send_item(make_item(OP_ADD, 32'h8000_0000, 8'd0));
        send_item(make_item(OP_ADD, 32'h7FFF_FFFF, 8'd0));
        send_item(make_item(OP_READ, 32'h0, 8'd0));
        send_item(make_item(OP_READ, 32'h0, 8'd15));
        send_item(make_item(OP_READ, 32'hFFFF_FFFF, 8'd255));
        send_item(make_item(OP_NOP, 32'h0, 8'd0));
        send_item(make_item(OP_CLEAR, 32'h0, 8'd0));
        send_item(make_item(OP_READ, 32'h0, 8'd0));
        drain();

        // Full 32-bit span, all 256 bins, half-open
        program_regs(32'h8000_0000, 32'h7FFF_FFFF, 9'd256, 1'b0, 1'b1);
        send_item(make_item(OP_ADD, 32'h8000_0000, 8'd0));
        send_item(make_item(OP_ADD, 32'h7FFF_FFFF, 8'd0));
        send_item(make_item(OP_ADD, 32'h7FFF_FFFE, 8'd0));
        send_item(make_item(OP_READ, 32'h0, 8'd255));
        drain();

        // Auto mode with bin count beyond the store
        program_regs(32'h8000_0000, 32'h7FFF_FFFF, 9'd511, 1'b1, 1'b0);
        send_item(make_item(OP_ADD, 32'h7FFF_FFFF, 8'd0));
        send_item(make_item(OP_ADD, 32'h0000_0000, 8'd0));
        drain();

        // Empty range in auto mode with a single bin requested
        program_regs(32'h0001_0000, 32'h0001_0000, 9'd1, 1'b1, 1'b0);
        send_item(make_item(OP_ADD, 32'h0001_0000, 8'd0));
        send_item(make_item(OP_ADD, 32'h0000_0000, 8'd0));
        drain();

        // Empty range in ranged mode, zero bins
        program_regs(32'h0001_0000, 32'h0001_0000, 9'd0, 1'b0, 1'b0);
        send_item(make_item(OP_ADD, 32'h0001_0000, 8'd0));
        drain();

        // Inverted range
        program_regs(32'd100, -32'sd100, 9'd8, 1'b1, 1'b0);
        send_item(make_item(OP_ADD, 32'h0000_0000, 8'd0));
        send_item(make_item(OP_ADD, 32'd100, 8'd0));
        drain();

        // Random phases, each under fresh settings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            am = 1'($urandom_range(0, 1));
            nb = $urandom_range(1, 256);
            case (p % 6)
                0:
                begin
                    lo = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
                    hi = lo + $urandom_range(1, 1 << 20);
                end
                1:
                begin
                    lo = -64'sd2147483648;
                    hi = 64'sd2147483647;
                    nb = ($urandom_range(0, 1)) ? 256 : nb;
                end
                2:
                begin
                    lo = longint'($signed($urandom));
                    hi = longint'($signed($urandom));
                    nb = $urandom_range(0, 511);
                end
                3:
                begin
                    lo = longint'($signed($urandom));
                    hi = lo;
                end
                4:
                begin
                    lo = longint'($urandom_range(0, 1 << 16)) - (1 << 15);
                    hi = lo + $urandom_range(1, 1 << 18);
                    nb = $urandom_range(0, 3);
                end
                default:
                begin
                    lo = -longint'($urandom_range(0, 32'h7FFF_FFFF));
                    hi = longint'($urandom_range(0, 32'h7FFF_FFFF));
                    nb = $urandom_range(200, 511);
                end
            endcase
            program_regs(lo[31:0], hi[31:0], nb[8:0], am, p[0]);
            idle_on <= (p != 5);
            hold_go <= (p == 3);
            random_phase(longint'($signed(lo[31:0])), longint'($signed(hi[31:0])), nb);
            hold_go <= 1'b0;
            drain();
        end

        // Let anything late show up before the verdict
        repeat (50) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d expected results never arrived",
                                     tracker.pending()));
        if (tracker.errors == 0)
            $display("PASS range_histogram_binner_unit");
        else
            $display("FAIL range_histogram_binner_unit");
        $finish;
    end

endmodule
